### rtl/core/efc_pkg.sv
package efc_pkg;

   // Field widths fixed by the frame format.
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned POS_W       = 14;
   localparam int unsigned LEN_W       = 17;
   localparam int unsigned QUEUE_DEPTH = 2;

   // CRC-16/CCITT-FALSE.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Legal frame length limits in bits: five header bytes up to 4096 bytes.
   localparam logic [LEN_W-1:0] LEN_BITS_FLOOR = LEN_W'(8 * 5);
   localparam logic [LEN_W-1:0] LEN_BITS_CEIL  = LEN_W'(8 * 4096);

   localparam logic [7:0] COUNTER_RESET = 8'hFF;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_MIN_LENGTH  = 3'd0,
      CSR_MAX_LENGTH  = 3'd1,
      CSR_HDR_OFFSET  = 3'd2,
      CSR_DATA_ID     = 3'd3,
      CSR_MAX_DELTA   = 3'd4
   } csr_index_type;

   // Detailed check status codes.
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NO_NEW_DATA  = 3'd1;
   localparam logic [2:0] ST_ERROR        = 3'd2;
   localparam logic [2:0] ST_REPEATED     = 3'd3;
   localparam logic [2:0] ST_WRONG_SEQ    = 3'd4;
   localparam logic [2:0] ST_OK_SOME_LOST = 3'd5;

   // Generic status codes.
   localparam logic [2:0] GEN_OK          = 3'd0;
   localparam logic [2:0] GEN_REPEATED    = 3'd1;
   localparam logic [2:0] GEN_WRONG_SEQ   = 3'd2;
   localparam logic [2:0] GEN_NO_NEW_DATA = 3'd3;
   localparam logic [2:0] GEN_ERROR       = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       no_data;
   } req_type;

   typedef struct packed {
      logic       return_code;
      logic [2:0] check_result;
      logic [2:0] generic_result;
      logic [7:0] seen_counter;
   } rsp_type;

   typedef struct packed {
      logic [15:0] min_length_bits;
      logic [15:0] max_length_bits;
      logic [15:0] header_offset_bits;
      logic [15:0] data_id;
      logic [7:0]  max_delta;
   } cfg_type;

   // One closed frame (or empty reception) handed from the front to the back.
   typedef struct packed {
      logic               no_data;
      logic [15:0]        crc;
      logic [COUNT_W-1:0] byte_count;
      logic [15:0]        rx_crc;
      logic [15:0]        rx_length;
      logic [7:0]         rx_seq;
   } frame_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [2:0] map_generic(input logic rc, input logic [2:0] st);
      logic [2:0] g;
      if (rc) begin
         g = GEN_ERROR;
      end else begin
         case (st)
            ST_OK, ST_OK_SOME_LOST: g = GEN_OK;
            ST_REPEATED:            g = GEN_REPEATED;
            ST_WRONG_SEQ:           g = GEN_WRONG_SEQ;
            ST_NO_NEW_DATA:         g = GEN_NO_NEW_DATA;
            default:                g = GEN_ERROR;
         endcase
      end
      return g;
   endfunction

endpackage

### rtl/core/efc_front.sv
module efc_front import efc_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   input  logic [15:0] header_offset_bits,
   input  logic        queue_full,
   output logic        push_en,
   output frame_type   push_data
);

   localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 2);

   logic [15:0]   crc_ff, crc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   rx_crc_ff, rx_crc_in;
   logic [15:0]   rx_len_ff, rx_len_in;
   logic [7:0]    rx_seq_ff, rx_seq_in;

   logic             accept;
   logic             frame_end;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] hoff;
   logic [7:0]       rb;

   // A transaction is taken whenever the queue has room for a closed frame.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign frame_end = req_payload.no_data || req_payload.last_byte;
   assign push_en   = accept && frame_end;

   // Byte-wise header capture and CRC update.
   always_comb begin
      pos       = POS_W'(count_ff);
      hoff      = POS_W'(header_offset_bits[15:3]);
      rb        = rev8(req_payload.data_byte);
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      rx_len_in = rx_len_ff;
      rx_seq_in = rx_seq_ff;
      if (pos == hoff) begin
         rx_crc_in = {rb, rx_crc_ff[7:0]};
      end else if (pos == hoff + POS_W'(1)) begin
         rx_crc_in = {rx_crc_ff[15:8], rb};
      end else begin
         if (pos == hoff + POS_W'(2)) begin
            rx_len_in = {rb, rx_len_ff[7:0]};
         end else if (pos == hoff + POS_W'(3)) begin
            rx_len_in = {rx_len_ff[15:8], rb};
         end else if (pos == hoff + POS_W'(4)) begin
            rx_seq_in = rb;
         end
         crc_in = crc_byte(crc_ff, req_payload.data_byte);
      end
      // The count saturates one past the largest legal frame.
      if (count_ff <= CW'(MAX_FRAME_BYTES)) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Record of the closed frame for the back end.
   always_comb begin
      push_data            = '0;
      push_data.no_data    = req_payload.no_data;
      if (!req_payload.no_data) begin
         push_data.crc        = crc_in;
         push_data.byte_count = COUNT_W'(count_in);
         push_data.rx_crc     = rx_crc_in;
         push_data.rx_length  = rx_len_in;
         push_data.rx_seq     = rx_seq_in;
      end
   end

   // Frame state; any closing transaction returns it to the start of frame.
   always_ff @(posedge clock) begin
      if (reset || (accept && frame_end)) begin
         crc_ff    <= CRC_INIT;
         count_ff  <= '0;
         rx_crc_ff <= '0;
         rx_len_ff <= '0;
         rx_seq_ff <= '0;
      end else if (accept) begin
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         rx_crc_ff <= rx_crc_in;
         rx_len_ff <= rx_len_in;
         rx_seq_ff <= rx_seq_in;
      end
   end

endmodule

### rtl/core/efc_queue.sv
module efc_queue import efc_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_en,
   input  frame_type                    push_data,
   output logic                         full,
   input  logic                         pop_en,
   output frame_type                    pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   fill
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned FW = $clog2(DEPTH + 1);

   frame_type     entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] count_ff, count_in;

   assign full     = (count_ff == FW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign fill     = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + FW'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/efc_back.sv
module efc_back import efc_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      queue_empty,
   input  frame_type pop_data,
   output logic      pop_en,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   // Stage one: rule checks and CRC over the data id high byte.
   logic        s1_valid_ff;
   frame_type   s1_frame_ff;
   logic [15:0] s1_crc_ff;
   logic        s1_wrong_ff;

   // Stage two: output register and receiver state.
   logic        out_valid_ff;
   rsp_type     out_ff, out_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  last_counter_ff, last_counter_in;

   logic             out_free, s1_move, s1_free;
   logic [LEN_W-1:0] min_len, max_len, len_bits, off_end;
   logic             cfg_bad, wrong;
   logic [15:0]      crc_final;
   logic             crc_match;
   logic [7:0]       delta;
   logic             rc;
   logic [7:0]       seen;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign pop_en    = !queue_empty && s1_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // Configuration and frame rule checks on the record at the queue head.
   always_comb begin
      min_len  = LEN_W'(cfg.min_length_bits);
      max_len  = LEN_W'(cfg.max_length_bits);
      len_bits = {1'b0, pop_data.byte_count, 3'b000};
      off_end  = LEN_W'(cfg.header_offset_bits) + LEN_BITS_FLOOR;
      cfg_bad  = (min_len < LEN_BITS_FLOOR) || (max_len < LEN_BITS_FLOOR) ||
                 (min_len > LEN_BITS_CEIL) || (max_len > LEN_BITS_CEIL) ||
                 (min_len > max_len);
      wrong    = cfg_bad;
      if (!pop_data.no_data) begin
         wrong = cfg_bad ||
                 (pop_data.byte_count > COUNT_W'(MAX_FRAME_BYTES)) ||
                 (len_bits < min_len) || (len_bits > max_len) ||
                 (cfg.header_offset_bits[2:0] != 3'b000) ||
                 (off_end > len_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= pop_en;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_en) begin
         s1_frame_ff <= pop_data;
         s1_crc_ff   <= crc_byte(pop_data.crc, cfg.data_id[15:8]);
         s1_wrong_ff <= wrong;
      end
   end

   // Final CRC byte, sequence evaluation and result build.
   always_comb begin
      crc_final       = crc_byte(s1_crc_ff, cfg.data_id[7:0]);
      crc_match       = (crc_final == s1_frame_ff.rx_crc) &&
                        (s1_frame_ff.rx_length == 16'(s1_frame_ff.byte_count));
      delta           = s1_frame_ff.rx_seq - last_counter_ff;
      status_in       = status_ff;
      last_counter_in = last_counter_ff;
      rc              = 1'b0;
      seen            = 8'h00;
      if (s1_wrong_ff) begin
         rc = 1'b1;
      end else if (s1_frame_ff.no_data) begin
         status_in = ST_NO_NEW_DATA;
      end else if (!crc_match) begin
         status_in = ST_ERROR;
         seen      = s1_frame_ff.rx_seq;
      end else begin
         if (delta > cfg.max_delta) begin
            status_in = ST_WRONG_SEQ;
         end else if (delta == 8'd0) begin
            status_in = ST_REPEATED;
         end else if (delta == 8'd1) begin
            status_in = ST_OK;
         end else begin
            status_in = ST_OK_SOME_LOST;
         end
         last_counter_in = s1_frame_ff.rx_seq;
         seen            = s1_frame_ff.rx_seq;
      end
      out_in.return_code    = rc;
      out_in.check_result   = status_in;
      out_in.generic_result = map_generic(rc, status_in);
      out_in.seen_counter   = seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         status_ff       <= ST_ERROR;
         last_counter_ff <= COUNTER_RESET;
      end else begin
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            status_ff       <= status_in;
            last_counter_ff <= last_counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

endmodule

### rtl/core/e2e_frame_checker_unit.sv
// Channel    Direction  Handshake              Content
// req_*      in         req_valid / req_ready  one frame byte, last mark, empty flag
// rsp_*      out        rsp_valid / rsp_ready  return code, status, generic status, counter
// csr_*      in         csr_valid / csr_ready  register index and write data
//
// One byte is taken every cycle while the frame queue is not full; the CRC update
// and header capture finish in that cycle. A result passes from its closing transaction
// through the frame queue, the check stage register and then the output register.
// Reset is synchronous and needs no clearing pass; csr_ready is always high.
// The two-entry frame queue lets the byte front keep going while a result is stalled.
module e2e_frame_checker_unit import efc_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

   cfg_type       cfg_ff;
   logic          push_en, pop_en, queue_full, queue_empty;
   frame_type     push_data, pop_data;
   logic [FW-1:0] queue_fill;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length_bits    <= 16'd40;
         cfg_ff.max_length_bits    <= 16'd32768;
         cfg_ff.header_offset_bits <= 16'd0;
         cfg_ff.data_id            <= 16'd0;
         cfg_ff.max_delta          <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_LENGTH: cfg_ff.min_length_bits    <= csr_data;
            CSR_MAX_LENGTH: cfg_ff.max_length_bits    <= csr_data;
            CSR_HDR_OFFSET: cfg_ff.header_offset_bits <= csr_data;
            CSR_DATA_ID:    cfg_ff.data_id            <= csr_data;
            CSR_MAX_DELTA:  cfg_ff.max_delta          <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Byte front: CRC accumulation and header capture.
   efc_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload        (req_payload),
      .header_offset_bits (cfg_ff.header_offset_bits),
      .queue_full         (queue_full),
      .push_en            (push_en),
      .push_data          (push_data)
   );

   // Queue of closed frames.
   efc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (push_data),
      .full      (queue_full),
      .pop_en    (pop_en),
      .pop_data  (pop_data),
      .empty     (queue_empty),
      .fill      (queue_fill)
   );

   // Check back end: rules, final CRC, sequence and status.
   efc_back #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop_en      (pop_en),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   // The frame queue never holds more records than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      queue_fill <= FW'(QUEUE_DEPTH))
      else $error("frame queue overfilled");

   // A rule violation always maps to the generic error status and no counter.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.return_code) |->
      (rsp_payload.generic_result == GEN_ERROR && rsp_payload.seen_counter == 8'h00))
      else $error("input error not reported as generic error");

   // An accepted empty reception reaches the queue in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.no_data) |=> !queue_empty)
      else $error("empty reception lost before the queue");

   // A valid empty reception carries no counter.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.return_code &&
       rsp_payload.check_result == ST_NO_NEW_DATA) |->
      (rsp_payload.seen_counter == 8'h00 && rsp_payload.generic_result == GEN_NO_NEW_DATA))
      else $error("empty reception result inconsistent");
`endif

endmodule
